>>> src/gla_pkg.sv
// ----------------------------------------------------------------------------
// gla_pkg
// Shared constants and codes for the G-code line assembler: buffer size,
// character codes the parser looks for, and the line status codes.
// ----------------------------------------------------------------------------
package gla_pkg;

  // Line buffer capacity in bytes, and the width of a count that can hold it
  localparam int LINE_CAPACITY = 256;
  localparam int FILL_W        = $clog2(LINE_CAPACITY + 1);

  // Characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UPPER_N = 8'h4E;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_RX_ERR = 8'h7F;

  // Line end status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_RESEND   = 3'd3,
    ST_BAD_SUM  = 3'd4,
    ST_NO_SUM   = 3'd5
  } line_status_t;

endpackage

>>> src/gcode_line_assembler.sv
// ----------------------------------------------------------------------------
// gcode_line_assembler
// Byte-at-a-time G-code line parser: line number, comments, quoted strings,
// XOR checksum check, and line buffer store/index generation.
// ----------------------------------------------------------------------------
// Each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one byte per cycle unless the result stream stalls; each byte
//   is parsed by one pass of logic from state registers to output register.
// Reset (rst_n low, synchronous): parser idle, counts and sums cleared,
//   checksum_required cleared, output register empty.
// ----------------------------------------------------------------------------
module gcode_line_assembler (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: checksum_required
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] at_top_level
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [0] store_valid, [8:1] store_index,
                                  // [16:9] store_byte, [19:17] line_status,
                                  // [28:20] line_length, [60:29] line_number,
                                  // [63:61] zero
  output logic        out_tlast   // line_done
);
  import gla_pkg::*;

  typedef enum logic [2:0] {
    PS_IDLE    = 3'd0,
    PS_LNUM    = 3'd1,
    PS_WS      = 3'd2,
    PS_CMD     = 3'd3,
    PS_BRACKET = 3'd4,
    PS_QUOTE   = 3'd5,
    PS_SUM     = 3'd6,
    PS_DISCARD = 3'd7
  } parse_state_t;

  // Parser state
  parse_state_t      state_r, state_nxt, st_eff;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [31:0]       lnum_r, lnum_nxt;
  logic              saw_ln_r, saw_ln_nxt;
  logic              saw_sum_r, saw_sum_nxt;
  logic              cfg_sum_req_r;

  // Output register
  logic              out_valid_r;
  logic              st_valid_r, st_valid_nxt;
  logic [7:0]        st_index_r, st_index_nxt;
  logic [7:0]        st_byte_r, st_byte_nxt;
  logic              done_r, done_nxt;
  line_status_t      status_r, status_nxt;
  logic [8:0]        length_r, length_nxt;
  logic [31:0]       onum_r, onum_nxt;

  // Byte decode
  logic [7:0] c;
  logic [3:0] digit;
  logic       is_eol, is_space, is_n, is_dig, has_room, accept;

  assign c        = in_tdata;
  assign digit    = 4'(c - CH_ZERO);
  assign is_eol   = (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
  assign is_space = (c == CH_SPACE) || (c == CH_TAB);
  assign is_n     = (c == CH_UPPER_N) || (c == CH_LOWER_N);
  assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign has_room = fill_r < FILL_W'(LINE_CAPACITY);

  // Take a new byte whenever the output register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Resolve the state that actually handles this byte (idle or line number
  // falls through whitespace into command text)
  always_comb begin
    st_eff = state_r;
    if (st_eff == PS_IDLE && !(is_n || is_space)) st_eff = PS_CMD;
    if (st_eff == PS_LNUM && !is_dig)             st_eff = PS_WS;
    if (st_eff == PS_WS && !is_space)             st_eff = PS_CMD;
  end

  // Parse one byte
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    xor_nxt      = xor_r;
    sum_nxt      = sum_r;
    lnum_nxt     = lnum_r;
    saw_ln_nxt   = saw_ln_r;
    saw_sum_nxt  = saw_sum_r;
    st_valid_nxt = 1'b0;
    st_index_nxt = 8'd0;
    st_byte_nxt  = 8'd0;
    done_nxt     = 1'b0;
    status_nxt   = ST_OK;
    length_nxt   = 9'd0;
    onum_nxt     = 32'd0;

    if (is_eol) begin
      // End of line: report status and clear the line
      done_nxt   = 1'b1;
      length_nxt = 9'(fill_r);
      if (fill_r == '0) begin
        status_nxt = ST_EMPTY;
      end else if (!has_room) begin
        status_nxt = ST_OVERFLOW;
      end else if (saw_sum_r && (xor_r != sum_r)) begin
        if (saw_ln_r) begin
          status_nxt = ST_RESEND;
          onum_nxt   = lnum_r;
        end else begin
          status_nxt = ST_BAD_SUM;
        end
      end else if (cfg_sum_req_r && !saw_sum_r && in_tuser) begin
        status_nxt = ST_NO_SUM;
      end
      state_nxt   = PS_IDLE;
      fill_nxt    = '0;
      xor_nxt     = 8'd0;
      sum_nxt     = 8'd0;
      lnum_nxt    = 32'd0;
      saw_ln_nxt  = 1'b0;
      saw_sum_nxt = 1'b0;
    end else if (c == CH_RX_ERR && state_r != PS_DISCARD) begin
      // Receive error: drop the buffer contents and discard the rest
      fill_nxt  = '0;
      state_nxt = PS_DISCARD;
    end else begin
      state_nxt = st_eff;
      case (st_eff)
        PS_IDLE: begin
          xor_nxt = xor_r ^ c;
          if (is_n) begin
            saw_ln_nxt = 1'b1;
            lnum_nxt   = 32'd0;
            state_nxt  = PS_LNUM;
          end
        end
        PS_LNUM: begin
          xor_nxt  = xor_r ^ c;
          lnum_nxt = {lnum_r[28:0], 3'b000} + {lnum_r[30:0], 1'b0} + 32'(digit);
        end
        PS_WS: begin
          xor_nxt = xor_r ^ c;
        end
        PS_CMD: begin
          if (c == CH_STAR) begin
            sum_nxt     = 8'd0;
            saw_sum_nxt = 1'b1;
            state_nxt   = PS_SUM;
          end else if (c == CH_SEMI) begin
            state_nxt = PS_DISCARD;
          end else if (c == CH_LPAREN) begin
            xor_nxt   = xor_r ^ c;
            state_nxt = PS_BRACKET;
          end else begin
            xor_nxt = xor_r ^ c;
            if (has_room) begin
              st_valid_nxt = 1'b1;
              st_index_nxt = 8'(fill_r);
              st_byte_nxt  = c;
              fill_nxt     = fill_r + 1'b1;
            end
            if (c == CH_QUOTE) state_nxt = PS_QUOTE;
          end
        end
        PS_BRACKET: begin
          xor_nxt = xor_r ^ c;
          if (c == CH_RPAREN) state_nxt = PS_CMD;
        end
        PS_QUOTE: begin
          xor_nxt = xor_r ^ c;
          if (has_room) begin
            st_valid_nxt = 1'b1;
            st_index_nxt = 8'(fill_r);
            st_byte_nxt  = c;
            fill_nxt     = fill_r + 1'b1;
          end
          if (c == CH_QUOTE) state_nxt = PS_CMD;
        end
        PS_SUM: begin
          if (is_dig) begin
            sum_nxt = {sum_r[4:0], 3'b000} + {sum_r[6:0], 1'b0} + 8'(digit);
          end else begin
            state_nxt = PS_DISCARD;
          end
        end
        default: begin
          // discarding: drop everything up to the line end
        end
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sum_req_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_sum_req_r <= cfg_wr_data;
    end
  end

  // Parser state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PS_IDLE;
      fill_r      <= '0;
      xor_r       <= 8'd0;
      sum_r       <= 8'd0;
      lnum_r      <= 32'd0;
      saw_ln_r    <= 1'b0;
      saw_sum_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r   <= state_nxt;
        fill_r    <= fill_nxt;
        xor_r     <= xor_nxt;
        sum_r     <= sum_nxt;
        lnum_r    <= lnum_nxt;
        saw_ln_r  <= saw_ln_nxt;
        saw_sum_r <= saw_sum_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on each accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      st_valid_r <= st_valid_nxt;
      st_index_r <= st_index_nxt;
      st_byte_r  <= st_byte_nxt;
      done_r     <= done_nxt;
      status_r   <= status_nxt;
      length_r   <= length_nxt;
      onum_r     <= onum_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {3'b000, onum_r, length_r, status_r, st_byte_r, st_index_r, st_valid_r};

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(LINE_CAPACITY))
    else $error("fill count beyond line capacity");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_eol |=> state_r == PS_IDLE && fill_r == '0 && !saw_sum_r)
    else $error("line end did not clear the parser");

  a_done_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !st_valid_r)
    else $error("line end beat also stores a byte");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> status_r == ST_OK && length_r == 9'd0 && onum_r == 32'd0)
    else $error("line status reported without line end");

  a_resend_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_RESEND |-> onum_r == 32'd0)
    else $error("line number reported without resend status");

endmodule

>>> tb/gcode_line_assembler_tb.sv
// ----------------------------------------------------------------------------
// gcode_line_assembler_tb
// Self-checking bench for the G-code line assembler. A queue of received
// bytes, built from well-formed lines with random content plus raw noise,
// feeds a clocked stream driver. A clocked monitor predicts every result
// beat with its own copy of the parser state and compares it field by field.
// The checksum rule is switched between phases while the block is idle.
// ----------------------------------------------------------------------------
module gcode_line_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gla_pkg::*;

  localparam int         QUIET_LIMIT = 2000;
  localparam int         LONG_HOLD   = 60;
  localparam int         MAX_REPORTS = 100;
  localparam logic [7:0] CHR_G       = 8'h47;
  localparam logic [7:0] CHR_M       = 8'h4D;

  // Parser phases as tracked by the predictor
  typedef enum logic [2:0] {
    P_IDLE    = 3'd0,
    P_LNUM    = 3'd1,
    P_WS      = 3'd2,
    P_CMD     = 3'd3,
    P_BRACKET = 3'd4,
    P_QUOTE   = 3'd5,
    P_SUM     = 3'd6,
    P_DISCARD = 3'd7
  } parse_phase_t;

  typedef enum int {SUM_NONE, SUM_GOOD, SUM_BAD} sum_kind_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       top;
  } rx_item_t;

  typedef struct packed {
    logic         stored;
    logic [7:0]   slot;
    logic [7:0]   chr;
    logic         done;
    line_status_t status;
    logic [8:0]   length;
    logic [31:0]  lnum;
  } line_beat_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] rx_byte
  logic        in_tuser    = 1'b0; // [0] at_top_level
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [63:0] out_tdata;          // [0] store_valid, [8:1] store_index,
                                   // [16:9] store_byte, [19:17] line_status,
                                   // [28:20] line_length, [60:29] line_number
  logic        out_tlast;          // line_done

  // Predictor state and its copy of the checksum rule
  parse_phase_t ps       = P_IDLE;
  int unsigned  fill     = 0;
  logic [7:0]   xsum     = '0;
  logic [7:0]   stated   = '0;
  logic [31:0]  lnum     = '0;
  bit           saw_n    = 1'b0;
  bit           saw_star = 1'b0;
  bit           sum_required = 1'b0;

  rx_item_t   rx_pending[$];
  line_beat_t line_expect[$];

  bit in_beat      = 1'b0;
  bit out_beat     = 1'b0;
  bit steady       = 1'b0;
  bit long_hold_go = 1'b0;
  int send_gap     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int quiet        = 0;
  int fails        = 0;
  int items_queued = 0;
  int beats_in     = 0;
  int status_seen[6] = '{default: 0};

  gcode_line_assembler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the line parser by one byte and return the beat it should produce
  function automatic line_beat_t parse_byte(logic [7:0] c, logic top);
    line_beat_t r;
    bit redo;
    int k;
    r = '0;
    if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
      r.done   = 1'b1;
      r.length = 9'(fill);
      if (fill == 0) begin
        r.status = ST_EMPTY;
      end else if (fill >= LINE_CAPACITY) begin
        r.status = ST_OVERFLOW;
      end else if (saw_star && xsum != stated) begin
        if (saw_n) begin
          r.status = ST_RESEND;
          r.lnum   = lnum;
        end else begin
          r.status = ST_BAD_SUM;
        end
      end else if (sum_required && !saw_star && top) begin
        r.status = ST_NO_SUM;
      end else begin
        r.status = ST_OK;
      end
      ps = P_IDLE;
      fill = 0;
      xsum = '0;
      stated = '0;
      lnum = '0;
      saw_n = 1'b0;
      saw_star = 1'b0;
      return r;
    end

    // A receive error throws the line away
    if (c == CH_RX_ERR && ps != P_DISCARD) begin
      fill = 0;
      ps = P_DISCARD;
    end

    // Idle and line number may hand the same byte on to the command phase
    for (k = 0; k < 4; k++) begin
      redo = 1'b0;
      case (ps)
        P_IDLE: begin
          if (c == CH_UPPER_N || c == CH_LOWER_N) begin
            saw_n = 1'b1;
            xsum ^= c;
            lnum = '0;
            ps = P_LNUM;
          end else if (c == CH_SPACE || c == CH_TAB) begin
            xsum ^= c;
          end else begin
            ps = P_CMD;
            redo = 1'b1;
          end
        end
        P_LNUM: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            xsum ^= c;
            lnum = lnum * 32'd10 + 32'(c - CH_ZERO);
          end else begin
            ps = P_WS;
            redo = 1'b1;
          end
        end
        P_WS: begin
          if (c == CH_SPACE || c == CH_TAB) begin
            xsum ^= c;
          end else begin
            ps = P_CMD;
            redo = 1'b1;
          end
        end
        P_CMD: begin
          if (c == CH_STAR) begin
            stated = '0;
            saw_star = 1'b1;
            ps = P_SUM;
          end else if (c == CH_SEMI) begin
            ps = P_DISCARD;
          end else if (c == CH_LPAREN) begin
            xsum ^= c;
            ps = P_BRACKET;
          end else begin
            xsum ^= c;
            if (fill < LINE_CAPACITY) begin
              r.stored = 1'b1;
              r.slot   = 8'(fill);
              r.chr    = c;
              fill++;
            end
            if (c == CH_QUOTE) ps = P_QUOTE;
          end
        end
        P_BRACKET: begin
          xsum ^= c;
          if (c == CH_RPAREN) ps = P_CMD;
        end
        P_QUOTE: begin
          xsum ^= c;
          if (fill < LINE_CAPACITY) begin
            r.stored = 1'b1;
            r.slot   = 8'(fill);
            r.chr    = c;
            fill++;
          end
          if (c == CH_QUOTE) ps = P_CMD;
        end
        P_SUM: begin
          if (c >= CH_ZERO && c <= CH_NINE) stated = 8'(stated * 10 + (c - CH_ZERO));
          else ps = P_DISCARD;
        end
        default: ;
      endcase
      if (!redo) break;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("t=%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Predict on input beats, check on result beats, watch for a hang
  always @(posedge clk) begin
    line_beat_t want;
    line_beat_t seen;
    in_beat  = rst_n && in_tvalid && in_tready;
    out_beat = rst_n && out_tvalid && out_tready;
    if (in_beat) begin
      seen = parse_byte(in_tdata, in_tuser);
      if (seen.done) status_seen[int'(seen.status)]++;
      line_expect.push_back(seen);
      beats_in++;
    end
    if (out_beat) begin
      if (line_expect.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("t=%0t result beat with nothing expected: tdata 0x%0h, tlast %0b",
                   $time, out_tdata, out_tlast);
      end else begin
        want = line_expect.pop_front();
        check_field("store_valid", want.stored, out_tdata[0]);
        check_field("store_index", want.slot, out_tdata[8:1]);
        check_field("store_byte", want.chr, out_tdata[16:9]);
        check_field("line_status", want.status, out_tdata[19:17]);
        check_field("line_length", want.length, out_tdata[28:20]);
        check_field("line_number", want.lnum, out_tdata[60:29]);
        check_field("tdata pad", '0, out_tdata[63:61]);
        check_field("line_done", want.done, out_tlast);
      end
    end
    if (in_beat || out_beat) begin
      quiet = 0;
    end else if (rst_n) begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timed out after %0d cycles without a beat", quiet);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer queued bytes, with random idle bursts except during a long hold-off
  always @(negedge clk) begin
    rx_item_t item;
    if (rst_n && (!in_tvalid || in_beat)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (rx_pending.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!steady && hold_left == 0 && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 5);
        in_tvalid <= 1'b0;
      end else begin
        item = rx_pending.pop_front();
        in_tdata  <= item.chr;
        in_tuser  <= item.top;
        in_tvalid <= 1'b1;
      end
    end
  end

  // Accept results, with random stalls and one long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (long_hold_go) begin
        long_hold_go = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(logic [7:0] c, logic top);
    rx_pending.push_back('{chr: c, top: top});
    items_queued++;
  endtask

  task automatic push_text(string s, logic top);
    foreach (s[i]) push_byte(s[i], top);
  endtask

  // Random byte that cannot end the line or raise a receive error
  function automatic logic [7:0] pick_byte(logic [7:0] closer, bit body);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == CH_LF || b == CH_CR || b == CH_RX_ERR || b == closer ||
               (body && (b == CH_STAR || b == CH_SEMI || b == CH_LPAREN || b == CH_QUOTE)));
    return b;
  endfunction

  // Build one line with about body_len stored bytes and the chosen checksum
  task automatic queue_line(int body_len, sum_kind_t kind, bit may_break);
    logic [7:0] txt[$];
    logic [7:0] x;
    string      digits;
    int         stored;
    int         pick;
    txt = {};
    x = '0;
    stored = 0;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    if ($urandom_range(0, 1)) begin
      txt.push_back($urandom_range(0, 1) ? CH_UPPER_N : CH_LOWER_N);
      repeat ($urandom_range(0, 12)) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      repeat ($urandom_range(0, 2)) txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
    // open with a command letter so every later body byte lands in the buffer
    if (body_len > 0) begin
      txt.push_back($urandom_range(0, 1) ? CHR_G : CHR_M);
      stored++;
    end
    while (stored < body_len) begin
      pick = $urandom_range(0, 9);
      if (body_len - stored >= 7 && pick == 0) begin
        txt.push_back(CH_LPAREN);
        repeat ($urandom_range(0, 5)) txt.push_back(pick_byte(CH_RPAREN, 1'b0));
        txt.push_back(CH_RPAREN);
      end else if (body_len - stored >= 7 && pick == 1) begin
        txt.push_back(CH_QUOTE);
        stored++;
        repeat ($urandom_range(0, 5)) begin
          txt.push_back(pick_byte(CH_QUOTE, 1'b0));
          stored++;
        end
        txt.push_back(CH_QUOTE);
        stored++;
      end else begin
        txt.push_back(pick_byte(CH_NUL, 1'b1));
        stored++;
      end
    end
    // everything so far enters the XOR
    foreach (txt[i]) x ^= txt[i];
    if (kind != SUM_NONE) begin
      txt.push_back(CH_STAR);
      if (kind == SUM_GOOD)
        digits = $sformatf("%0d",
                 int'(x) + 256 * ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0));
      else
        digits = $sformatf("%0d", x ^ 8'($urandom_range(1, 255)));
      if ($urandom_range(0, 7) == 0) digits = {"0", digits};
      foreach (digits[i]) txt.push_back(digits[i]);
    end
    if ($urandom_range(0, 4) == 0) begin
      txt.push_back(CH_SEMI);
      repeat ($urandom_range(0, 4)) txt.push_back(pick_byte(CH_NUL, 1'b0));
    end
    if (may_break && $urandom_range(0, 24) == 0)
      txt.insert($urandom_range(0, txt.size()), CH_RX_ERR);
    case ($urandom_range(0, 2))
      0: txt.push_back(CH_NUL);
      1: txt.push_back(CH_LF);
      default: txt.push_back(CH_CR);
    endcase
    foreach (txt[i]) push_byte(txt[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_random_line();
    int r;
    int m;
    r = $urandom_range(0, 99);
    m = $urandom_range(0, 19);
    if (r < 12) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      queue_line($urandom_range(0, 14), m < 7 ? SUM_NONE : (m < 16 ? SUM_GOOD : SUM_BAD), 1'b1);
    end
  endtask

  task automatic fill_random(int n);
    int target;
    target = items_queued + n;
    while (items_queued < target) queue_random_line();
  endtask

  // Wait until every queued byte has produced its result
  task automatic drain();
    while (beats_in != items_queued || line_expect.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_checksum_rule(logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sum_required = v;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    set_checksum_rule(1'b0);

    // Directed: empty line, NUL end, comments and quotes, receive error,
    // resend with a line number, wide checksum
    push_byte(CH_LF, 1'b1);
    push_text("G1", 1'b1);
    push_byte(CH_NUL, 1'b1);
    push_text("(a)M\"*\";", 1'b1);
    push_byte(CH_CR, 1'b0);
    push_text("G", 1'b1);
    push_byte(CH_RX_ERR, 1'b1);
    push_byte(CH_LF, 1'b1);
    push_text("N9G*1", 1'b1);
    push_byte(CH_LF, 1'b1);
    push_text("G*583", 1'b1);
    push_byte(CH_CR, 1'b1);
    drain();

    // Checksum required: missing sum at top level and inside a macro
    set_checksum_rule(1'b1);
    push_text("G", 1'b1);
    push_byte(CH_LF, 1'b1);
    push_text("G", 1'b0);
    push_byte(CH_LF, 1'b0);
    fill_random(400);
    drain();

    // Long receiver hold-off so the block backs up onto its input
    set_checksum_rule(1'b0);
    long_hold_go = 1'b1;
    fill_random(400);
    drain();

    // Full buffer: one line that just fits, one that fills it, one past it
    set_checksum_rule(1'b1);
    queue_line(LINE_CAPACITY - 1, SUM_GOOD, 1'b0);
    queue_line(LINE_CAPACITY, SUM_NONE, 1'b0);
    queue_line(LINE_CAPACITY + 6, SUM_BAD, 1'b0);
    fill_random(150);
    drain();

    // Closing stretch at full rate on both sides
    set_checksum_rule(1'b0);
    steady = 1'b1;
    fill_random(250);
    drain();
    repeat (8) @(negedge clk);

    $display("Covered %0d input bytes, checksum rule on and off, idle bursts and a long hold-off",
             beats_in);
    $display("Line ends: ok %0d, empty %0d, overflow %0d, resend %0d, bad sum %0d, no sum %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_OVERFLOW],
             status_seen[ST_RESEND], status_seen[ST_BAD_SUM], status_seen[ST_NO_SUM]);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
